### sv/assert_macros.svh
// Assertion macros shared by the front end, queue and back end of the join order enumerator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// An antecedent in one cycle that forces a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/cjoe_pkg.sv
// Types, constants and helper functions of the join order enumerator.
`default_nettype none
package cjoe_pkg;
	localparam int unsigned SLOTS       = 8;
	localparam int unsigned NODE_W      = 3;
	localparam int unsigned COUNT_W     = 4;
	localparam int unsigned ADJ_W       = 64;
	localparam int unsigned MAX_NODES   = 8;
	localparam int unsigned FIFO_DEPTH  = 2;
	localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 4'd8;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [SLOTS-1:0][NODE_W-1:0] order_t;

	typedef struct packed {
		logic [COUNT_W-1:0] n;
		logic [ADJ_W-1:0]   adj;
	} cfg_t;

	typedef enum logic {
		REG_NODE_COUNT = 1'b0,
		REG_ADJACENCY  = 1'b1
	} reg_idx_t;

	function automatic order_t identity_order();
		order_t o;
		for (int p = 0; p < SLOTS; p++) begin
			o[p] = NODE_W'(p);
		end
		return o;
	endfunction

	function automatic logic [COUNT_W-1:0] active_count(logic [COUNT_W-1:0] raw,
			int unsigned max_nodes);
		logic [COUNT_W-1:0] v;
		v = raw;
		if (v < COUNT_W'(2)) v = COUNT_W'(2);
		if (v > COUNT_W'(max_nodes)) v = COUNT_W'(max_nodes);
		return v;
	endfunction

	function automatic logic is_permutation(order_t o);
		logic [SLOTS-1:0] seen;
		seen = '0;
		for (int p = 0; p < SLOTS; p++) begin
			seen[o[p]] = 1'b1;
		end
		return &seen;
	endfunction
endpackage
`default_nettype wire

### sv/cjoe_front.sv
// Front end: holds the current order, accepts ticks and steps to the next permutation.
`default_nettype none
`include "assert_macros.svh"
module cjoe_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cjoe_pkg::cfg_t cfg,
	input  wire logic           reload,
	input  wire logic           accept,
	input  wire logic           restart,
	output cjoe_pkg::order_t    emit
);
	import cjoe_pkg::*;

	order_t              cur_q;
	order_t              swp;
	order_t              nxt;
	logic                found;
	node_t               pivot;
	node_t               jsel;
	logic [COUNT_W-1:0]  n;

	assign n = cfg.n;

	always_comb begin
		emit  = restart ? identity_order() : cur_q;
		found = 1'b0;
		pivot = '0;
		for (int i = 0; i < SLOTS - 1; i++) begin
			if (COUNT_W'(i + 1) < n && emit[i] < emit[i+1]) begin
				found = 1'b1;
				pivot = NODE_W'(i);
			end
		end
		// The suffix after the pivot is descending, so the last larger entry
		// is the smallest one above the pivot value.
		jsel = '0;
		for (int j = 0; j < SLOTS; j++) begin
			if (COUNT_W'(j) < n && NODE_W'(j) > pivot && emit[j] > emit[pivot]) begin
				jsel = NODE_W'(j);
			end
		end
		swp        = emit;
		swp[pivot] = emit[jsel];
		swp[jsel]  = emit[pivot];
		nxt        = emit;
		for (int p = 0; p < SLOTS; p++) begin
			if (found) begin
				if (NODE_W'(p) > pivot && COUNT_W'(p) < n) begin
					nxt[p] = swp[NODE_W'(n + {1'b0, pivot} - COUNT_W'(p))];
				end else begin
					nxt[p] = swp[p];
				end
			end else if (COUNT_W'(p) < n) begin
				// Last order wraps: reverse the whole active range.
				nxt[p] = emit[NODE_W'(n - COUNT_W'(1) - COUNT_W'(p))];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= identity_order();
		end else if (reload) begin
			cur_q <= identity_order();
		end else if (accept) begin
			cur_q <= nxt;
		end
	end

	`ASSERT_ALWAYS(a_front_perm, clk, arst_n, is_permutation(cur_q), "order lost a node")
endmodule
`default_nettype wire

### sv/cjoe_fifo.sv
// Short queue of emitted orders between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module cjoe_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire cjoe_pkg::order_t wdata,
	input  wire logic             pop,
	output cjoe_pkg::order_t      rdata,
	output logic                  full,
	output logic                  empty
);
	import cjoe_pkg::*;

	order_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_fifo_no_overflow, clk, arst_n, !(push && full), "push into full queue")
	`ASSERT_ALWAYS(a_fifo_no_underflow, clk, arst_n, !(pop && empty), "pop from empty queue")
endmodule
`default_nettype wire

### sv/cjoe_back.sv
// Back end: computes the connected and last-order flags and holds the result register.
`default_nettype none
`include "assert_macros.svh"
module cjoe_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cjoe_pkg::cfg_t   cfg,
	input  wire logic             head_valid,
	input  wire cjoe_pkg::order_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output cjoe_pkg::order_t      order_out,
	output logic                  connected,
	output logic                  final_order
);
	import cjoe_pkg::*;

	logic             valid_q;
	order_t           order_q;
	logic             connected_q;
	logic             final_q;
	logic [SLOTS-1:0] marked;
	logic [SLOTS-1:0] all_mask;
	logic [SLOTS-1:0] nb;
	logic             conn_c;
	logic             last_c;

	assign pop = head_valid && (!valid_q || out_ready);

	always_comb begin
		marked   = '0;
		all_mask = '0;
		nb       = '0;
		last_c   = 1'b1;
		marked[head[0]] = 1'b1;
		for (int p = 1; p < SLOTS; p++) begin
			if (COUNT_W'(p) < cfg.n) begin
				nb = cfg.adj[{head[p], 3'b000} +: SLOTS];
				if ((nb & marked) != '0) marked[head[p]] = 1'b1;
			end
		end
		for (int p = 0; p < SLOTS; p++) begin
			if (COUNT_W'(p) < cfg.n) all_mask[p] = 1'b1;
		end
		for (int p = 0; p < SLOTS - 1; p++) begin
			if (COUNT_W'(p + 1) < cfg.n && head[p] < head[p+1]) last_c = 1'b0;
		end
		conn_c = ((marked & all_mask) == all_mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			order_q     <= head;
			connected_q <= conn_c;
			final_q     <= last_c;
		end
	end

	assign out_valid   = valid_q;
	assign order_out   = order_q;
	assign connected   = connected_q;
	assign final_order = final_q;

	`ASSERT_NEXT(a_back_pop_loads, clk, arst_n, pop, valid_q, "popped order not presented")
endmodule
`default_nettype wire

### sv/connected_join_order_enumerator.sv
// Top level of the join order enumerator: register port, front end, queue and back end.
//
//   Channel  Direction  Handshake               Contents
//   in       input      in_valid / in_ready     restart
//   out      output     out_valid / out_ready   slot0..slot7, connected, final_order
//   config   input      APB psel/penable/pready node_count (0x0), adjacency (0x8)
//
// One transaction per cycle is sustained in both directions while out_ready stays high.
// A taken input is written into the queue, and its result is registered when the back end pops
// it; the permutation step and the marking walk are each combinational logic.
// Reset loads the identity order, node_count 8 and an empty adjacency matrix.
// Under an output stall the output register and the two-entry queue hold three results
// before in_ready drops; it rises again at the edge that takes the stalled result.
`default_nettype none
module connected_join_order_enumerator #(
	parameter int unsigned MAX_NODES_P = cjoe_pkg::MAX_NODES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       slot0,
	output logic [2:0]       slot1,
	output logic [2:0]       slot2,
	output logic [2:0]       slot3,
	output logic [2:0]       slot4,
	output logic [2:0]       slot5,
	output logic [2:0]       slot6,
	output logic [2:0]       slot7,
	output logic             connected,
	output logic             final_order
);
	import cjoe_pkg::*;

	logic [COUNT_W-1:0] node_count_q;
	logic [ADJ_W-1:0]   adjacency_q;
	reg_idx_t           reg_idx;
	logic               wr_en;
	logic               reload;
	cfg_t               cfg;
	logic               accept;
	order_t             emit;
	order_t             head;
	order_t             order_out;
	logic               fifo_full;
	logic               fifo_empty;
	logic               pop;

	// Registers sit eight bytes apart; the low address bits are not decoded.
	assign reg_idx = reg_idx_t'(paddr[3]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reload  = wr_en && (reg_idx == REG_NODE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			adjacency_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NODE_COUNT: node_count_q <= pwdata[COUNT_W-1:0];
				REG_ADJACENCY:  adjacency_q  <= pwdata;
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NODE_COUNT: prdata = {{(64 - COUNT_W){1'b0}}, node_count_q};
			REG_ADJACENCY:  prdata = adjacency_q;
			default:        prdata = '0;
		endcase
	end

	// Counts outside the supported range are clamped to the nearest end.
	assign cfg.n   = active_count(node_count_q, MAX_NODES_P);
	assign cfg.adj = adjacency_q;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	cjoe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.reload  (reload),
		.accept  (accept),
		.restart (restart),
		.emit    (emit)
	);

	cjoe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (emit),
		.pop    (pop),
		.rdata  (head),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	cjoe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head_valid  (!fifo_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.order_out   (order_out),
		.connected   (connected),
		.final_order (final_order)
	);

	assign slot0 = order_out[0];
	assign slot1 = order_out[1];
	assign slot2 = order_out[2];
	assign slot3 = order_out[3];
	assign slot4 = order_out[4];
	assign slot5 = order_out[5];
	assign slot6 = order_out[6];
	assign slot7 = order_out[7];
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the connected join order enumerator.
`default_nettype none
module tb;
	import cjoe_pkg::*;

	// The run normally ends well before the limit; the limit only guards against a
	// block that stops answering.
	localparam int CYCLE_LIMIT = 400000;
	// Share of cycles, in percent, in which either side idles when left to chance.
	localparam int IDLE_PCT = 21;
	// Window, counted in transactions, in which neither side idles.
	localparam int STEADY_FROM = 1000;
	localparam int STEADY_TO = 1300;
	// After this many results, the receiver holds off long enough to back the input up.
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 250;

	// One emitted order with its two flags, as the output channel should carry it.
	typedef struct packed {
		logic [SLOTS-1:0][NODE_W-1:0] slot;
		logic conn;
		logic last;
	} order_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] slot0, slot1, slot2, slot3, slot4, slot5, slot6, slot7;
	logic connected;
	logic final_order;

	connected_join_order_enumerator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot0(slot0),
		.slot1(slot1),
		.slot2(slot2),
		.slot3(slot3),
		.slot4(slot4),
		.slot5(slot5),
		.slot6(slot6),
		.slot7(slot7),
		.connected(connected),
		.final_order(final_order)
	);

	// Predictor state: the configuration as last written and the order that the next input
	// transaction will emit.
	logic [COUNT_W-1:0] count_reg = NODE_COUNT_RESET;
	logic [ADJ_W-1:0] adj_reg = '0;
	logic [NODE_W-1:0] perm_state [SLOTS];

	// Restart bits waiting to be offered, and the orders still owed by the block.
	bit restart_pending[$];
	order_result_t expected_orders[$];

	int failures = 0;
	int cycle_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Prints one line for the mismatch and counts it.
	task automatic report_failure(input string msg);
		$display("ERROR: %s", msg);
		failures++;
	endtask

	task automatic reset_perm();
		for (int p = 0; p < SLOTS; p++) begin
			perm_state[p] = NODE_W'(p);
		end
	endtask

	// Appends one restart bit to the transactions waiting to be offered.
	task automatic add_tick(input bit rs);
		restart_pending.insert(restart_pending.size(), rs);
	endtask

	// Node counts below two behave as two, counts above the maximum as the maximum.
	function automatic int nodes_in_play(input logic [COUNT_W-1:0] raw);
		if (raw < COUNT_W'(2))
			return 2;
		if (raw > COUNT_W'(MAX_NODES))
			return MAX_NODES;
		return int'(raw);
	endfunction

	// Works out the result of one input transaction, queues it, and steps the order to its
	// lexicographic successor (the descending order wraps to the identity).
	task automatic predict_result(input logic reload);
		int n;
		int v;
		int pivot;
		int j;
		int lo;
		int hi;
		logic [NODE_W-1:0] t;
		logic [8:0] marked;
		logic [8:0] all_nodes;
		order_result_t r;
		n = nodes_in_play(count_reg);
		if (reload)
			reset_perm();
		for (int p = 0; p < SLOTS; p++) begin
			r.slot[p] = perm_state[p];
		end
		// Walk the order: a node is marked only if one of its neighbors is already marked,
		// so a node passed over early stays unmarked even if later nodes would reach it.
		marked = 9'd1 << perm_state[0];
		for (int p = 1; p < n; p++) begin
			v = perm_state[p];
			if ((adj_reg[v*8 +: 8] & marked[7:0]) != 8'd0)
				marked[v] = 1'b1;
		end
		all_nodes = (9'd1 << n) - 9'd1;
		r.conn = ((marked & all_nodes) == all_nodes);
		r.last = 1'b1;
		for (int p = 0; p + 1 < n; p++) begin
			if (perm_state[p] < perm_state[p+1])
				r.last = 1'b0;
		end
		expected_orders.insert(expected_orders.size(), r);

		pivot = -1;
		for (int p = 0; p + 1 < n; p++) begin
			if (perm_state[p] < perm_state[p+1])
				pivot = p;
		end
		if (pivot < 0) begin
			lo = 0;
		end else begin
			j = n - 1;
			while (perm_state[j] <= perm_state[pivot])
				j--;
			t = perm_state[pivot];
			perm_state[pivot] = perm_state[j];
			perm_state[j] = t;
			lo = pivot + 1;
		end
		hi = n - 1;
		while (lo < hi) begin
			t = perm_state[lo];
			perm_state[lo] = perm_state[hi];
			perm_state[hi] = t;
			lo++;
			hi--;
		end
	endtask

	// A write has a setup phase and then an access phase; the register takes the value at the
	// edge that closes the access phase, since pready is always high. Registers sit on
	// eight-byte steps because the adjacency register is 64 bits wide.
	task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_NODE_COUNT) begin
			// Any node count write also brings the order back to the identity.
			count_reg = value[COUNT_W-1:0];
			reset_perm();
		end else begin
			adj_reg = value;
		end
	endtask

	// Waits until every queued transaction has been taken and every owed result has come
	// back, then lets the pipeline settle before returning.
	task automatic wait_drained();
		@(negedge clk);
		while (restart_pending.size() != 0 || in_valid || expected_orders.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(input logic [COUNT_W-1:0] count, input logic [63:0] adj,
			input bit write_count);
		wait_drained();
		apb_write(REG_ADJACENCY, adj);
		if (write_count)
			apb_write(REG_NODE_COUNT, 64'(count));
		@(negedge clk);
	endtask

	task automatic queue_random(input int cnt, input int restart_pct);
		for (int i = 0; i < cnt; i++) begin
			add_tick($urandom_range(0, 99) < restart_pct);
		end
	endtask

	// Sender. Each accepted transaction is run through the predictor at the edge that
	// accepts it. A transaction that is offered stays offered, with its restart bit
	// unchanged, until in_ready takes it; only between transactions may the sender idle.
	always @(posedge clk or negedge arst_n) begin : drive
		int accepted_cnt;
		bit stalled;
		bit idle_now;
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
			accepted_cnt = 0;
		end else begin
			stalled = in_valid && !in_ready;
			if (in_valid && in_ready) begin
				predict_result(restart);
				accepted_cnt++;
			end
			if (!stalled) begin
				idle_now = !(accepted_cnt >= STEADY_FROM && accepted_cnt < STEADY_TO) &&
					($urandom_range(0, 99) < IDLE_PCT);
				if (restart_pending.size() != 0 && !idle_now) begin
					in_valid <= 1'b1;
					restart <= restart_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker. Every result transaction is compared field by field with the
	// oldest owed result. out_ready is chosen once per edge: random idling, a quiet window,
	// and once a long hold-off that fills the block's two-entry queue and stalls its input
	// while the sender keeps offering.
	always @(posedge clk or negedge arst_n) begin : collect
		int results_seen;
		int hold_left;
		bit hold_done;
		bit ready_next;
		logic [SLOTS-1:0][NODE_W-1:0] got;
		order_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			results_seen = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {slot7, slot6, slot5, slot4, slot3, slot2, slot1, slot0};
				if (expected_orders.size() == 0) begin
					report_failure($sformatf("result %0d arrived with nothing owed",
						results_seen));
				end else begin
					want = expected_orders.pop_front();
					for (int p = 0; p < SLOTS; p++) begin
						if (got[p] !== want.slot[p])
							report_failure($sformatf("result %0d slot%0d: got %0d, want %0d",
								results_seen, p, got[p], want.slot[p]));
					end
					if (connected !== want.conn)
						report_failure($sformatf("result %0d connected: got %b, want %b",
							results_seen, connected, want.conn));
					if (final_order !== want.last)
						report_failure($sformatf("result %0d final_order: got %b, want %b",
							results_seen, final_order, want.last));
				end
				results_seen++;
			end
			if (hold_left != 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				ready_next = 1'b0;
			end else if (results_seen >= STEADY_FROM && results_seen < STEADY_TO) begin
				ready_next = 1'b1;
			end else begin
				ready_next = ($urandom_range(0, 99) >= IDLE_PCT);
			end
			out_ready <= ready_next;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus: a directed part that walks the corner cases, then random phases. Every
	// phase boundary is a full drain, so the sender pauses until all owed results are back
	// before the registers change.
	initial begin : stimulus
		logic [COUNT_W-1:0] count;
		logic [63:0] adj;
		int pick;
		reset_perm();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: eight nodes, no edges, so nothing is connected.
		add_tick(1'b0);
		add_tick(1'b0);

		// Two nodes, full graph: both orders, the last one flagged, then the wrap.
		configure(4'd2, '1, 1'b1);
		repeat (3) add_tick(1'b0);

		// Three nodes: the full cycle of six orders and the wrap, then a restart.
		configure(4'd3, '1, 1'b1);
		repeat (7) add_tick(1'b0);
		add_tick(1'b1);
		add_tick(1'b0);

		// A zero node count acts as two; only node 1 lists node 0 as a neighbor, so the
		// identity is connected and the reversed order is not.
		configure(4'd0, 64'h0000_0000_0000_0100, 1'b1);
		repeat (2) add_tick(1'b0);

		// A node count of one also acts as two.
		configure(4'd1, 64'h0000_0000_0000_0100, 1'b1);
		repeat (2) add_tick(1'b0);

		// Counts above the maximum act as the maximum. Edges only in the byte of node 7.
		configure(4'd15, 64'hFF00_0000_0000_0000, 1'b1);
		add_tick(1'b0);
		add_tick(1'b1);
		configure(4'd9, 64'h5555_AAAA_5555_AAAA, 1'b1);
		repeat (2) add_tick(1'b0);

		// A chain 0-1-2: in the order 0,2,1 node 2 is passed over before node 1 is marked,
		// so that order is not connected even though the graph is.
		configure(4'd3, 64'h0000_0000_0002_0502, 1'b1);
		repeat (3) add_tick(1'b0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			pick = $urandom_range(0, 3);
			count = (pick == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(2, 8));
			pick = $urandom_range(0, 4);
			case (pick)
				0: adj = '1;
				1: adj = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
				2: adj = {$urandom, $urandom} | {$urandom, $urandom};
				default: adj = {$urandom, $urandom};
			endcase
			// Leaving the node count alone now and then checks that an adjacency write
			// does not disturb the order in progress.
			configure(count, adj, (ph == 0) || ($urandom_range(0, 1) == 1));
			queue_random(ITEMS_PER_PHASE, 2);
		end

		wait_drained();
		repeat (6) @(negedge clk);
		if (expected_orders.size() != 0)
			report_failure($sformatf("%0d results never arrived", expected_orders.size()));
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire
